/* hdl/ccs_pkg.sv */
package ccs_pkg;

    // bus and field widths
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // configuration register indexes (paddr[3:2])
    localparam logic [1:0] REG_YEAR_LOW      = 2'd0;
    localparam logic [1:0] REG_YEAR_HIGH     = 2'd1;
    localparam logic [1:0] REG_VIEW_YEAR_LOW = 2'd2;
    localparam logic [1:0] REG_VIEW_HOLD     = 2'd3;

    // configuration reset values
    localparam logic [11:0] YEAR_LOW_RST      = 12'd2000;
    localparam logic [11:0] YEAR_HIGH_RST     = 12'd2099;
    localparam logic [11:0] VIEW_YEAR_LOW_RST = 12'd1900;
    localparam logic [7:0]  VIEW_HOLD_RST     = 8'd30;

    // calendar constants
    localparam logic [11:0] YEAR_RST = 12'd2000;
    localparam logic [11:0] YEAR_TOP = 12'd4095;

    // operating modes
    localparam logic [2:0] MODE_RUN    = 3'd0;
    localparam logic [2:0] MODE_YEAR   = 3'd1;
    localparam logic [2:0] MODE_MONTH  = 3'd2;
    localparam logic [2:0] MODE_DAY    = 3'd3;
    localparam logic [2:0] MODE_HOUR   = 3'd4;
    localparam logic [2:0] MODE_MINUTE = 3'd5;

    // date unit operations
    localparam logic OP_MLEN    = 1'b0;
    localparam logic OP_WEEKDAY = 1'b1;

    typedef struct packed {
        logic [5:0] elapsed_seconds;
        logic       press_up;
        logic       press_down;
        logic       press_set;
    } item_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  mode;
        logic [11:0] view_year;
        logic [3:0]  view_month;
        logic [2:0]  weekday_today;
        logic [2:0]  view_first_weekday;
        logic [4:0]  view_month_days;
    } result_t;

    typedef struct packed {
        logic [11:0] year_low;
        logic [11:0] year_high;
        logic [11:0] view_year_low;
        logic [7:0]  view_hold;
    } cfg_t;

    typedef struct packed {
        logic        start;
        logic        op;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } calc_req_t;

    typedef struct packed {
        logic       done;
        logic [4:0] value;
    } calc_rsp_t;

    // one step up or down with wraparound; below lo lands on hi, above hi on lo
    function automatic logic [11:0] wrap_step(input logic [11:0] x, input logic dec,
                                              input logic [11:0] lo, input logic [11:0] hi);
        logic signed [13:0] v;
        logic [11:0]        r;
        v = dec ? ($signed({2'b00, x}) - 14'sd1) : ($signed({2'b00, x}) + 14'sd1);
        if (v < $signed({2'b00, lo}))
            r = hi;
        else if (v > $signed({2'b00, hi}))
            r = lo;
        else
            r = v[11:0];
        return r;
    endfunction

    // days in a month
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        unique case (m)
            4'd2:                      d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

    // month term of the weekday sum, march based (jan and feb count as 13 and 14)
    function automatic logic [5:0] month_offset(input logic [3:0] m);
        logic [5:0] t;
        unique case (m)
            4'd1:    t = 6'd36;
            4'd2:    t = 6'd39;
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

endpackage

/* hdl/ccs_datecalc.sv */
module ccs_datecalc (
    input  logic               clk,
    input  logic               rst_n,
    input  ccs_pkg::calc_req_t req,
    output ccs_pkg::calc_rsp_t rsp
);
    import ccs_pkg::*;

    localparam logic [1:0] U_IDLE = 2'd0;
    localparam logic [1:0] U_MUL  = 2'd1;
    localparam logic [1:0] U_SUM  = 2'd2;
    localparam logic [1:0] U_MOD  = 2'd3;

    logic [1:0]  ustate_reg, ustate_next;
    logic        done_reg, done_next;
    logic        op_reg, op_next;
    logic [12:0] yy_reg, yy_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;
    logic [5:0]  toff_reg, toff_next;
    logic [5:0]  q_reg, q_next;
    logic [8:0]  sum_reg, sum_next;
    logic [4:0]  value_reg, value_next;

    logic        early;
    logic [25:0] prod;
    logic [12:0] hund;
    logic [12:0] zdiff;
    logic [6:0]  z;
    logic        leap;
    logic [8:0]  sum_in;
    logic [17:0] prod7;
    logic [5:0]  q7;
    logic [8:0]  rem;

    // datapath: century by reciprocal multiply, then remainder mod 7 by reciprocal
    always_comb
    begin
        early  = (req.month < 4'd3);
        prod   = {13'd0, yy_reg} * 26'd5243;
        hund   = {7'd0, q_reg} * 13'd100;
        zdiff  = yy_reg - hund;
        z      = zdiff[6:0];
        leap   = (yy_reg[1:0] == 2'd0) && ((z != 7'd0) || (q_reg[1:0] == 2'd0));
        sum_in = {4'd0, day_reg} + {3'd0, toff_reg} + {2'd0, z} + {4'd0, z[6:2]}
               + {1'b0, q_reg, 2'b00} + {3'd0, q_reg} + {5'd0, q_reg[5:2]} + 9'd6;
        prod7  = {9'd0, sum_reg} * 18'd293;
        q7     = prod7[16:11];
        rem    = sum_reg - ({3'd0, q7} * 9'd7);
    end

    // small sequencer over the reciprocal multiply datapath
    always_comb
    begin
        ustate_next = ustate_reg;
        done_next   = 1'b0;
        op_next     = op_reg;
        yy_next     = yy_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        toff_next   = toff_reg;
        q_next      = q_reg;
        sum_next    = sum_reg;
        value_next  = value_reg;
        unique case (ustate_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    op_next    = req.op;
                    month_next = req.month;
                    day_next   = req.day;
                    toff_next  = month_offset(req.month);
                    if (req.op == OP_WEEKDAY)
                        yy_next = {1'b0, req.year} + 13'd400 - {12'd0, early};
                    else
                        yy_next = {1'b0, req.year};
                    ustate_next = U_MUL;
                end
            end
            U_MUL:
            begin
                q_next      = prod[24:19];
                ustate_next = U_SUM;
            end
            U_SUM:
            begin
                if (op_reg == OP_MLEN)
                begin
                    value_next  = month_days(month_reg, leap);
                    done_next   = 1'b1;
                    ustate_next = U_IDLE;
                end
                else
                begin
                    sum_next    = sum_in;
                    ustate_next = U_MOD;
                end
            end
            default:
            begin
                value_next  = {2'b00, rem[2:0]};
                done_next   = 1'b1;
                ustate_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ustate_reg <= U_IDLE;
            done_reg   <= 1'b0;
        end
        else
        begin
            ustate_reg <= ustate_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        yy_reg    <= yy_next;
        month_reg <= month_next;
        day_reg   <= day_next;
        toff_reg  <= toff_next;
        q_reg     <= q_next;
        sum_reg   <= sum_next;
        value_reg <= value_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = value_reg;

endmodule

/* hdl/ccs_regs.sv */
module ccs_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ccs_pkg::ADDR_W-1:0]   paddr,
    input  logic [ccs_pkg::DATA_W-1:0]   pwdata,
    output logic [ccs_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output ccs_pkg::cfg_t                cfg
);
    import ccs_pkg::*;

    logic [11:0] year_low_reg, year_low_next;
    logic [11:0] year_high_reg, year_high_next;
    logic [11:0] view_year_low_reg, view_year_low_next;
    logic [7:0]  view_hold_reg, view_hold_next;
    logic        wr_en;
    logic [1:0]  index;

    assign wr_en  = psel && penable && pwrite;
    assign index  = paddr[ADDR_W-1:2];
    assign pready = 1'b1;

    // register write decode
    always_comb
    begin
        year_low_next      = year_low_reg;
        year_high_next     = year_high_reg;
        view_year_low_next = view_year_low_reg;
        view_hold_next     = view_hold_reg;
        if (wr_en)
        begin
            unique case (index)
                REG_YEAR_LOW:      year_low_next      = pwdata[11:0];
                REG_YEAR_HIGH:     year_high_next     = pwdata[11:0];
                REG_VIEW_YEAR_LOW: view_year_low_next = pwdata[11:0];
                default:           view_hold_next     = pwdata[7:0];
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (index)
            REG_YEAR_LOW:      prdata = {20'd0, year_low_reg};
            REG_YEAR_HIGH:     prdata = {20'd0, year_high_reg};
            REG_VIEW_YEAR_LOW: prdata = {20'd0, view_year_low_reg};
            default:           prdata = {24'd0, view_hold_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_low_reg      <= YEAR_LOW_RST;
            year_high_reg     <= YEAR_HIGH_RST;
            view_year_low_reg <= VIEW_YEAR_LOW_RST;
            view_hold_reg     <= VIEW_HOLD_RST;
        end
        else
        begin
            year_low_reg      <= year_low_next;
            year_high_reg     <= year_high_next;
            view_year_low_reg <= view_year_low_next;
            view_hold_reg     <= view_hold_next;
        end
    end

    assign cfg.year_low      = year_low_reg;
    assign cfg.year_high     = year_high_reg;
    assign cfg.view_year_low = view_year_low_reg;
    assign cfg.view_hold     = view_hold_reg;

endmodule

/* hdl/calendar_clock_with_setting.sv */
// Calendar clock with setting modes and month browsing. Each input transfer carries the
// seconds elapsed since the last one plus the up, down and set buttons, and yields one
// result transfer with the date, time, mode, browsed month, both weekdays and the browsed
// month's length. One item at a time is worked on: after acceptance the buttons act, a new
// month length is fetched when the year or month is set, normal mode ticks one second per
// cycle (clamped to MAX_TICKS) and pauses to fetch a new month length when those seconds
// roll into a new month, the view hold counts down, and the shared date unit then gives
// today's weekday, the browsed month's first weekday and its length, each by reciprocal
// multiplies. The next item is taken once the block is back in idle, even while the
// previous result still waits in the output register.
module calendar_clock_with_setting #(
    parameter int MAX_TICKS = 63
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  ccs_pkg::item_t               item,
    output logic                         result_valid,
    input  logic                         result_stall,
    output ccs_pkg::result_t             result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ccs_pkg::ADDR_W-1:0]   paddr,
    input  logic [ccs_pkg::DATA_W-1:0]   pwdata,
    output logic [ccs_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import ccs_pkg::*;

    localparam logic [7:0] TICK_LIMIT = 8'(MAX_TICKS);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_BTN  = 4'd1;
    localparam logic [3:0] S_LEN  = 4'd2;
    localparam logic [3:0] S_TICK = 4'd3;
    localparam logic [3:0] S_VIEW = 4'd4;
    localparam logic [3:0] S_WDT  = 4'd5;
    localparam logic [3:0] S_WDV  = 4'd6;
    localparam logic [3:0] S_MLV  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    cfg_t      cfg;
    calc_req_t calc_req;
    calc_rsp_t calc_rsp;

    // control and calendar state
    logic [3:0]  state_reg, state_next;
    logic [2:0]  mode_reg, mode_next;
    logic [11:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;
    logic [4:0]  mlen_reg, mlen_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [5:0]  second_reg, second_next;
    logic [11:0] view_year_reg, view_year_next;
    logic [3:0]  view_month_reg, view_month_next;
    logic [7:0]  hold_reg, hold_next;
    logic        issued_reg, issued_next;
    logic        out_valid_reg, out_valid_next;

    // per-item payload
    logic [5:0]  secs_reg, secs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        up_reg, up_next;
    logic        dn_reg, dn_next;
    logic [2:0]  wd_today_reg, wd_today_next;
    logic [2:0]  wd_view_reg, wd_view_next;
    logic [4:0]  vdays_reg, vdays_next;
    result_t     out_reg, out_next;

    logic        item_accept;
    logic [5:0]  secs_in;
    logic signed [9:0] hold_diff;
    logic [11:0] vm_step;
    logic [11:0] vy_step;
    logic [11:0] year_step;
    logic [11:0] month_step;
    logic [11:0] day_step;
    logic [11:0] hour_step;
    logic [11:0] minute_step;

    ccs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ccs_datecalc u_datecalc (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (calc_req),
        .rsp   (calc_rsp)
    );

    assign item_stall   = (state_reg != S_IDLE);
    assign item_accept  = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // clamp the elapsed seconds
    assign secs_in = ({2'b00, item.elapsed_seconds} > TICK_LIMIT) ? TICK_LIMIT[5:0]
                                                                   : item.elapsed_seconds;

    // one-step candidates for the button edits
    always_comb
    begin
        vm_step     = wrap_step({8'd0, view_month_reg}, dn_reg, 12'd1, 12'd12);
        vy_step     = wrap_step(view_year_reg, dn_reg, cfg.view_year_low, cfg.year_high);
        year_step   = wrap_step(year_reg, dn_reg, cfg.year_low, cfg.year_high);
        month_step  = wrap_step({8'd0, month_reg}, dn_reg, 12'd1, 12'd12);
        day_step    = wrap_step({7'd0, day_reg}, dn_reg, 12'd1, {7'd0, mlen_reg});
        hour_step   = wrap_step({7'd0, hour_reg}, dn_reg, 12'd0, 12'd23);
        minute_step = wrap_step({6'd0, minute_reg}, dn_reg, 12'd0, 12'd59);
    end

    // date unit request by sequencer step
    always_comb
    begin
        calc_req.start = 1'b0;
        calc_req.op    = OP_MLEN;
        calc_req.year  = year_reg;
        calc_req.month = month_reg;
        calc_req.day   = day_reg;
        unique case (state_reg)
            S_LEN:
            begin
                calc_req.start = !issued_reg;
            end
            S_WDT:
            begin
                calc_req.start = !issued_reg;
                calc_req.op    = OP_WEEKDAY;
            end
            S_WDV:
            begin
                calc_req.start = !issued_reg;
                calc_req.op    = OP_WEEKDAY;
                calc_req.year  = view_year_reg;
                calc_req.month = view_month_reg;
                calc_req.day   = 5'd1;
            end
            S_MLV:
            begin
                calc_req.start = !issued_reg;
                calc_req.year  = view_year_reg;
                calc_req.month = view_month_reg;
            end
            default:
            begin
            end
        endcase
    end

    // main sequencer
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        year_next       = year_reg;
        month_next      = month_reg;
        day_next        = day_reg;
        mlen_next       = mlen_reg;
        hour_next       = hour_reg;
        minute_next     = minute_reg;
        second_next     = second_reg;
        view_year_next  = view_year_reg;
        view_month_next = view_month_reg;
        hold_next       = hold_reg;
        secs_next       = secs_reg;
        cnt_next        = cnt_reg;
        up_next         = up_reg;
        dn_next         = dn_reg;
        wd_today_next   = wd_today_reg;
        wd_view_next    = wd_view_reg;
        vdays_next      = vdays_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && result_stall;
        hold_diff       = $signed({2'b00, hold_reg}) - $signed({4'b0000, secs_reg});

        // request handshake with the date unit
        issued_next = issued_reg;
        if (calc_req.start)
            issued_next = 1'b1;
        if (calc_rsp.done)
            issued_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_accept)
                begin
                    secs_next = secs_in;
                    cnt_next  = secs_in;
                    up_next   = item.press_up;
                    dn_next   = item.press_down;
                    if (item.press_set)
                        mode_next = (mode_reg == MODE_MINUTE) ? MODE_RUN : mode_reg + 3'd1;
                    state_next = S_BTN;
                end
            end

            // buttons act in the mode just selected; up with down cancels
            S_BTN:
            begin
                state_next = S_TICK;
                if (up_reg != dn_reg)
                begin
                    if (mode_reg == MODE_RUN)
                    begin
                        view_month_next = vm_step[3:0];
                        if ((!dn_reg && vm_step[3:0] == 4'd1) || (dn_reg && vm_step[3:0] == 4'd12))
                            view_year_next = vy_step;
                        hold_next = cfg.view_hold;
                    end
                    else
                    begin
                        unique case (mode_reg)
                            MODE_YEAR:
                            begin
                                year_next  = year_step;
                                state_next = S_LEN;
                            end
                            MODE_MONTH:
                            begin
                                month_next = month_step[3:0];
                                state_next = S_LEN;
                            end
                            MODE_DAY:
                            begin
                                day_next = day_step[4:0];
                            end
                            MODE_HOUR:
                            begin
                                hour_next   = hour_step[4:0];
                                second_next = 6'd0;
                            end
                            default:
                            begin
                                minute_next = minute_step[5:0];
                                second_next = 6'd0;
                            end
                        endcase
                    end
                end
            end

            // new month length, day clamped to it
            S_LEN:
            begin
                if (calc_rsp.done)
                begin
                    mlen_next = calc_rsp.value;
                    if (day_reg > calc_rsp.value)
                        day_next = calc_rsp.value;
                    state_next = S_TICK;
                end
            end

            // one second per cycle, normal mode only; a month rollover pauses for the new month length
            S_TICK:
            begin
                if (mode_reg == MODE_RUN && cnt_reg != 6'd0)
                begin
                    cnt_next = cnt_reg - 6'd1;
                    if (second_reg != 6'd59)
                        second_next = second_reg + 6'd1;
                    else
                    begin
                        second_next = 6'd0;
                        if (minute_reg != 6'd59)
                            minute_next = minute_reg + 6'd1;
                        else
                        begin
                            minute_next = 6'd0;
                            if (hour_reg != 5'd23)
                                hour_next = hour_reg + 5'd1;
                            else
                            begin
                                hour_next = 5'd0;
                                if (day_reg < mlen_reg)
                                    day_next = day_reg + 5'd1;
                                else
                                begin
                                    day_next = 5'd1;
                                    if (month_reg != 4'd12)
                                        month_next = month_reg + 4'd1;
                                    else
                                    begin
                                        month_next = 4'd1;
                                        if (year_reg != YEAR_TOP)
                                            year_next = year_reg + 12'd1;
                                    end
                                    state_next = S_LEN;
                                end
                            end
                        end
                    end
                end
                else
                    state_next = S_VIEW;
            end

            // hold countdown, view falls back to today
            S_VIEW:
            begin
                if (mode_reg == MODE_RUN)
                begin
                    if (secs_reg != 6'd0)
                    begin
                        if (hold_diff <= 10'sd0)
                        begin
                            view_year_next  = year_reg;
                            view_month_next = month_reg;
                            hold_next       = 8'd0;
                        end
                        else
                            hold_next = hold_diff[7:0];
                    end
                end
                else
                begin
                    view_year_next  = year_reg;
                    view_month_next = month_reg;
                    hold_next       = 8'd0;
                end
                state_next = S_WDT;
            end

            S_WDT:
            begin
                if (calc_rsp.done)
                begin
                    wd_today_next = calc_rsp.value[2:0];
                    state_next    = S_WDV;
                end
            end

            S_WDV:
            begin
                if (calc_rsp.done)
                begin
                    wd_view_next = calc_rsp.value[2:0];
                    state_next   = S_MLV;
                end
            end

            S_MLV:
            begin
                if (calc_rsp.done)
                begin
                    vdays_next = calc_rsp.value;
                    state_next = S_FIN;
                end
            end

            // load the output register once it is free
            S_FIN:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_next.year               = year_reg;
                    out_next.month              = month_reg;
                    out_next.day                = day_reg;
                    out_next.hour               = hour_reg;
                    out_next.minute             = minute_reg;
                    out_next.second             = second_reg;
                    out_next.mode               = mode_reg;
                    out_next.view_year          = view_year_reg;
                    out_next.view_month         = view_month_reg;
                    out_next.weekday_today      = wd_today_reg;
                    out_next.view_first_weekday = wd_view_reg;
                    out_next.view_month_days    = vdays_reg;
                    out_valid_next              = 1'b1;
                    state_next                  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= MODE_RUN;
            year_reg       <= YEAR_RST;
            month_reg      <= 4'd1;
            day_reg        <= 5'd1;
            mlen_reg       <= 5'd31;
            hour_reg       <= 5'd0;
            minute_reg     <= 6'd0;
            second_reg     <= 6'd0;
            view_year_reg  <= YEAR_RST;
            view_month_reg <= 4'd1;
            hold_reg       <= 8'd0;
            issued_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            year_reg       <= year_next;
            month_reg      <= month_next;
            day_reg        <= day_next;
            mlen_reg       <= mlen_next;
            hour_reg       <= hour_next;
            minute_reg     <= minute_next;
            second_reg     <= second_next;
            view_year_reg  <= view_year_next;
            view_month_reg <= view_month_next;
            hold_reg       <= hold_next;
            issued_reg     <= issued_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        secs_reg     <= secs_next;
        cnt_reg      <= cnt_next;
        up_reg       <= up_next;
        dn_reg       <= dn_next;
        wd_today_reg <= wd_today_next;
        wd_view_reg  <= wd_view_next;
        vdays_reg    <= vdays_next;
        out_reg      <= out_next;
    end

endmodule

/* hdl/ccs_checker.sv */
module ccs_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input logic             result_valid,
    input logic             result_stall,
    input ccs_pkg::result_t result
);
    import ccs_pkg::*;

    // a waiting result stays put until its transfer
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // one item at a time: the cycle after a transfer the input is stalled
    a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("second item taken while busy");

    // time of day stays in range
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.hour <= 5'd23) && (result.minute <= 6'd59)
                         && (result.second <= 6'd59))
        else $error("time of day out of range");

    // shown month is a real month with a real length
    a_view_month: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.view_month >= 4'd1) && (result.view_month <= 4'd12)
                         && (result.view_month_days >= 5'd28)
                         && (result.view_month_days <= 5'd31))
        else $error("shown month out of range");

    // in a setting mode the view tracks today
    a_view_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.mode != MODE_RUN)
            |-> (result.view_year == result.year) && (result.view_month == result.month))
        else $error("view does not follow today while setting");

endmodule

bind calendar_clock_with_setting ccs_checker u_ccs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

/* tb/calendar_clock_with_setting_tb.sv */
module calendar_clock_with_setting_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ccs_pkg::*;

    localparam int TICK_LIMIT = 63;
    localparam int TAIL_CYCLES = 100;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    item_t item;
    logic result_valid;
    logic result_stall;
    result_t result;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    calendar_clock_with_setting #(
        .MAX_TICKS (TICK_LIMIT)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // idle rates and receiver hold-off
    int send_idle_pct;
    int recv_idle_pct;
    int recv_hold_left;
    int mismatches;

    result_t expected_readouts[$];

    // limits as programmed into the block
    int lim_year_low;
    int lim_year_high;
    int lim_view_year_low;
    int lim_hold;

    // predicted clock and view state
    logic [2:0] cal_mode;
    int cal_year;
    int cal_month;
    int cal_day;
    int cal_mlen;
    int cal_hour;
    int cal_min;
    int cal_sec;
    int view_yr;
    int view_mo;
    int view_hold_left;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("calendar_clock_with_setting: mismatch");
        $finish;
    end

    function automatic int wrap_within(int v, int lo, int hi);
        if (v < lo)
            v = hi;
        if (v > hi)
            v = lo;
        return v;
    endfunction

    function automatic int days_in_month(int y, int m);
        if (m == 2)
            return ((y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0))) ? 29 : 28;
        return (m == 4 || m == 6 || m == 9 || m == 11) ? 30 : 31;
    endfunction

    // zeller congruence shifted by 400 years, 0 is sunday
    function automatic int weekday_for(int y, int m, int d);
        int yy;
        int mm;
        int z;
        int c;
        yy = y + 400;
        mm = m;
        if (mm <= 2)
        begin
            yy = yy - 1;
            mm = mm + 12;
        end
        z = yy % 100;
        c = yy / 100;
        return (d + 26 * (mm + 1) / 10 + z + z / 4 + 5 * c + c / 4 + 6) % 7;
    endfunction

    task automatic reset_calendar();
        lim_year_low = YEAR_LOW_RST;
        lim_year_high = YEAR_HIGH_RST;
        lim_view_year_low = VIEW_YEAR_LOW_RST;
        lim_hold = VIEW_HOLD_RST;
        cal_mode = MODE_RUN;
        cal_year = YEAR_RST;
        cal_month = 1;
        cal_day = 1;
        cal_mlen = 31;
        cal_hour = 0;
        cal_min = 0;
        cal_sec = 0;
        view_yr = YEAR_RST;
        view_mo = 1;
        view_hold_left = 0;
    endtask

    // one second of wall time, carrying up to the year
    function automatic void tick_one_second();
        cal_sec++;
        if (cal_sec <= 59)
            return;
        cal_sec = 0;
        cal_min++;
        if (cal_min <= 59)
            return;
        cal_min = 0;
        cal_hour++;
        if (cal_hour <= 23)
            return;
        cal_hour = 0;
        cal_day++;
        if (cal_day <= cal_mlen)
            return;
        cal_day = 1;
        cal_month++;
        if (cal_month > 12)
        begin
            cal_month = 1;
            if (cal_year < YEAR_TOP)
                cal_year++;
        end
        cal_mlen = days_in_month(cal_year, cal_month);
    endfunction

    // apply one button/tick item and return the readout it produces
    function automatic result_t advance_calendar(item_t it);
        int secs;
        int vel;
        result_t r;
        secs = it.elapsed_seconds;
        vel = int'(it.press_up) - int'(it.press_down);
        if (secs > TICK_LIMIT)
            secs = TICK_LIMIT;
        if (it.press_set)
            cal_mode = (cal_mode == MODE_MINUTE) ? MODE_RUN : cal_mode + 3'd1;

        if (cal_mode == MODE_RUN)
        begin
            // browse months, view year steps past december or january
            if (vel != 0)
            begin
                view_mo = wrap_within(view_mo + vel, 1, 12);
                if ((vel > 0 && view_mo == 1) || (vel < 0 && view_mo == 12))
                    view_yr = wrap_within(view_yr + vel, lim_view_year_low, lim_year_high);
                view_hold_left = lim_hold;
            end
            if (secs > 0)
            begin
                view_hold_left -= secs;
                for (int k = 0; k < secs; k++)
                    tick_one_second();
                if (view_hold_left <= 0)
                begin
                    view_yr = cal_year;
                    view_mo = cal_month;
                    view_hold_left = 0;
                end
            end
        end
        else
        begin
            // setting modes edit one field
            if (vel != 0)
            begin
                case (cal_mode)
                    MODE_YEAR:
                    begin
                        cal_year = wrap_within(cal_year + vel, lim_year_low, lim_year_high);
                        cal_mlen = days_in_month(cal_year, cal_month);
                        if (cal_day > cal_mlen)
                            cal_day = cal_mlen;
                    end
                    MODE_MONTH:
                    begin
                        cal_month = wrap_within(cal_month + vel, 1, 12);
                        cal_mlen = days_in_month(cal_year, cal_month);
                        if (cal_day > cal_mlen)
                            cal_day = cal_mlen;
                    end
                    MODE_DAY:
                        cal_day = wrap_within(cal_day + vel, 1, cal_mlen);
                    MODE_HOUR:
                    begin
                        cal_hour = wrap_within(cal_hour + vel, 0, 23);
                        cal_sec = 0;
                    end
                    default:
                    begin
                        cal_min = wrap_within(cal_min + vel, 0, 59);
                        cal_sec = 0;
                    end
                endcase
            end
            view_yr = cal_year;
            view_mo = cal_month;
            view_hold_left = 0;
        end

        r.year = cal_year[11:0];
        r.month = cal_month[3:0];
        r.day = cal_day[4:0];
        r.hour = cal_hour[4:0];
        r.minute = cal_min[5:0];
        r.second = cal_sec[5:0];
        r.mode = cal_mode;
        r.view_year = view_yr[11:0];
        r.view_month = view_mo[3:0];
        r.weekday_today = 3'(weekday_for(cal_year, cal_month, cal_day));
        r.view_first_weekday = 3'(weekday_for(view_yr, view_mo, 1));
        r.view_month_days = 5'(days_in_month(view_yr, view_mo));
        return r;
    endfunction

    // receiver stall pattern, driven at the falling edge
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (recv_hold_left > 0)
            begin
                result_stall = 1'b1;
                recv_hold_left--;
            end
            else
                result_stall = ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin : check_readout
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_readouts.size() == 0)
            begin
                $display("%0t: unexpected result transfer, actual %h", $time, result);
                mismatches++;
            end
            else
            begin
                want = expected_readouts.pop_front();
                check_field("year", want.year, result.year);
                check_field("month", want.month, result.month);
                check_field("day", want.day, result.day);
                check_field("hour", want.hour, result.hour);
                check_field("minute", want.minute, result.minute);
                check_field("second", want.second, result.second);
                check_field("mode", want.mode, result.mode);
                check_field("view_year", want.view_year, result.view_year);
                check_field("view_month", want.view_month, result.view_month);
                check_field("weekday_today", want.weekday_today, result.weekday_today);
                check_field("view_first_weekday", want.view_first_weekday,
                            result.view_first_weekday);
                check_field("view_month_days", want.view_month_days, result.view_month_days);
            end
        end
    end

    // offer one item, record its prediction once the transfer happens
    task automatic send_press(input item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item = it;
        item_valid = 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        expected_readouts.push_back(advance_calendar(it));
        @(negedge clk);
    endtask

    task automatic press(input int secs, input bit up, input bit down, input bit set);
        item_t it;
        it.elapsed_seconds = secs[5:0];
        it.press_up = up;
        it.press_down = down;
        it.press_set = set;
        send_press(it);
    endtask

    task automatic wait_for_results();
        item_valid = 1'b0;
        while (expected_readouts.size() != 0)
            @(posedge clk);
        @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // apb write then read back, block must be idle
    task automatic write_setting(input logic [1:0] idx, input int value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_YEAR_LOW:      lim_year_low = value;
            REG_YEAR_HIGH:     lim_year_high = value;
            REG_VIEW_YEAR_LOW: lim_view_year_low = value;
            default:           lim_hold = value;
        endcase
        @(negedge clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata != value)
        begin
            $display("%0t: register %0d expected %0d, actual %0d", $time, idx, value, prdata);
            mismatches++;
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    function automatic item_t random_press();
        item_t it;
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            it.elapsed_seconds = 6'd0;
        else if (pick < 55)
            it.elapsed_seconds = 6'd63;
        else
            it.elapsed_seconds = 6'($urandom_range(1, 62));
        it.press_set = ($urandom_range(99) < 15);
        it.press_up = ($urandom_range(99) < 35);
        it.press_down = ($urandom_range(99) < 35);
        return it;
    endfunction

    // new year limits and hold time, with extremes mixed in
    task automatic randomize_limits();
        int pick;
        int lo;
        int hi;
        int vlo;
        int hold;
        pick = $urandom_range(9);
        if (pick == 0)
        begin
            lo = 0;
            hi = 4095;
        end
        else if (pick == 1)
        begin
            lo = $urandom_range(4095);
            hi = lo;
        end
        else if (pick == 2)
        begin
            lo = $urandom_range(1, 4095);
            hi = $urandom_range(lo - 1);
        end
        else
        begin
            lo = $urandom_range(1500, 2100);
            hi = lo + $urandom_range(200);
        end
        pick = $urandom_range(3);
        vlo = (pick == 0) ? 0 : (pick == 1) ? lo : $urandom_range(lo);
        pick = $urandom_range(5);
        hold = (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(1, 120);
        write_setting(REG_YEAR_LOW, lo);
        write_setting(REG_YEAR_HIGH, hi);
        write_setting(REG_VIEW_YEAR_LOW, vlo);
        write_setting(REG_VIEW_HOLD, hold);
    endtask

    // browsing, cancel, hold expiry and one edit in every setting mode
    task automatic test_browse_and_modes();
        press(0, 0, 0, 0);
        press(0, 1, 0, 0);
        press(10, 0, 0, 0);
        press(0, 1, 1, 0);
        press(0, 0, 1, 0);
        press(0, 0, 1, 0);
        press(63, 0, 0, 0);
        press(0, 1, 0, 1);
        press(0, 1, 0, 1);
        press(0, 1, 0, 1);
        press(0, 1, 0, 1);
        press(0, 1, 0, 1);
        press(5, 0, 0, 1);
        wait_for_results();
    endtask

    // set 23:59 on dec 31 of year 4095, tick over, then a zero hold browse
    task automatic test_year_rollover();
        write_setting(REG_YEAR_LOW, 4095);
        write_setting(REG_YEAR_HIGH, 4095);
        write_setting(REG_VIEW_HOLD, 0);
        press(0, 1, 0, 1);
        press(0, 0, 1, 1);
        press(0, 0, 1, 0);
        press(0, 0, 1, 1);
        press(0, 0, 1, 0);
        press(0, 0, 1, 1);
        press(0, 0, 1, 0);
        press(0, 0, 1, 1);
        press(0, 0, 1, 0);
        press(63, 0, 0, 1);
        press(0, 1, 0, 0);
        press(1, 0, 0, 0);
        wait_for_results();
    endtask

    // long receiver hold-off while items keep coming
    task automatic test_output_backpressure();
        write_setting(REG_VIEW_YEAR_LOW, 0);
        write_setting(REG_VIEW_HOLD, 255);
        recv_hold_left = 400;
        for (int n = 0; n < 12; n++)
            send_press(random_press());
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int chunks, input int per_chunk);
        for (int c = 0; c < chunks; c++)
        begin
            randomize_limits();
            for (int n = 0; n < per_chunk; n++)
                send_press(random_press());
            wait_for_results();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        recv_hold_left = 0;
        send_idle_pct = 18;
        recv_idle_pct = 79;
        reset_calendar();
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_browse_and_modes();
        test_year_rollover();
        test_random_traffic(3, 150);

        send_idle_pct = 79;
        recv_idle_pct = 18;
        test_random_traffic(3, 150);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_output_backpressure();
        test_random_traffic(3, 150);

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("calendar_clock_with_setting: match");
        else
            $display("calendar_clock_with_setting: mismatch");
        $finish;
    end

endmodule
